>>> rtl/spb_pkg.sv
// ----------------------------------------------------------------------------
// spb_pkg
// Shared widths, register codes and reset values for the stereo bearing unit.
// ----------------------------------------------------------------------------
package spb_pkg;

    localparam int PIX_W    = 16;
    localparam int DIFF_W   = PIX_W + 1;
    localparam int SQ_W     = 2 * PIX_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int OUT_FRAC = 14;
    localparam int Q_W      = OUT_FRAC + 1;
    localparam int XY_W     = 16;
    localparam int Z_W      = 15;
    localparam int A_SHIFT  = 2 * (OUT_FRAC + 1);
    localparam int A_W      = SQ_W + A_SHIFT;
    localparam int ACC_W    = 72;
    localparam int CFG_IDX_W = 2;
    localparam int POINTS   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL    = 2'd0,
        CFG_CENTER_U = 2'd1,
        CFG_CENTER_V = 2'd2
    } t_cfg_idx;

    localparam logic [PIX_W-1:0] FOCAL_RESET    = 16'd8000;
    localparam logic [PIX_W-1:0] CENTER_U_RESET = 16'd5120;
    localparam logic [PIX_W-1:0] CENTER_V_RESET = 16'd3840;

    localparam logic [Q_W-1:0] Z_STRAIGHT = Q_W'(1) << OUT_FRAC;

endpackage

>>> rtl/spb_if.sv
// ----------------------------------------------------------------------------
// spb_if
// Channel interfaces: pixel pair words, bearing words and register writes.
// ----------------------------------------------------------------------------
interface spb_pair_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_u;
    logic [15:0] left_v;
    logic [15:0] right_u;
    logic [15:0] right_v;

    modport source (output valid, left_u, left_v, right_u, right_v, input ready);
    modport sink   (input valid, left_u, left_v, right_u, right_v, output ready);
endinterface

interface spb_bearing_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic        [14:0] left_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic        [14:0] right_z;

    modport source (output valid, left_x, left_y, left_z, right_x, right_y, right_z,
                    input ready);
    modport sink   (input valid, left_x, left_y, left_z, right_x, right_y, right_z,
                    output ready);
endinterface

interface spb_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/spb_search.sv
// ----------------------------------------------------------------------------
// spb_search
// Pipelined bit-by-bit search for round(mag * 2^14 / sqrt(s)), one bit per
// stage, using incremental square updates instead of multipliers.
// ----------------------------------------------------------------------------
module spb_search (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [spb_pkg::SQ_W-1:0]   i_sq,
    input  logic [spb_pkg::SUM_W-1:0]  i_s,
    output logic [spb_pkg::Q_W-1:0]    o_q
);
    import spb_pkg::*;

    logic signed [ACC_W-1:0] r_d [0:Q_W];
    logic signed [ACC_W-1:0] r_r [0:Q_W];
    logic        [SUM_W-1:0] r_s [0:Q_W];
    logic        [Q_W-1:0]   r_q [0:Q_W];

    logic signed [ACC_W-1:0] w_a_ext;
    logic signed [ACC_W-1:0] w_s_ext;

    assign w_a_ext = signed'({{(ACC_W-A_W){1'b0}}, i_sq, {A_SHIFT{1'b0}}});
    assign w_s_ext = signed'({{(ACC_W-SUM_W){1'b0}}, i_s});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= w_a_ext - w_s_ext;
            r_r[0] <= -w_s_ext;
            r_s[0] <= i_s;
            r_q[0] <= '0;
        end
    end

    for (genvar g = 0; g < Q_W; g++) begin : g_bit
        localparam int K = Q_W - 1 - g;
        logic signed [ACC_W-1:0] w_sx;
        logic signed [ACC_W-1:0] w_cand;

        assign w_sx   = signed'({{(ACC_W-SUM_W){1'b0}}, r_s[g]});
        assign w_cand = r_d[g] - (r_r[g] <<< (K + 2)) - (w_sx <<< (2 * K + 2));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[g+1] <= r_s[g];
                if (!w_cand[ACC_W-1]) begin
                    r_d[g+1] <= w_cand;
                    r_r[g+1] <= r_r[g] + (w_sx <<< (K + 1));
                    r_q[g+1] <= r_q[g] | (Q_W'(1) << K);
                end else begin
                    r_d[g+1] <= r_d[g];
                    r_r[g+1] <= r_r[g];
                    r_q[g+1] <= r_q[g];
                end
            end
        end
    end

    assign o_q = r_q[Q_W];

endmodule

>>> rtl/stereo_pixel_to_unit_bearing_unit.sv
// ----------------------------------------------------------------------------
// stereo_pixel_to_unit_bearing_unit
// Converts a stereo pair of Q12.4 pixel coordinates into two unit bearing
// vectors, x and y in signed Q2.14 and z in unsigned Q1.14, rounded to nearest.
//
// The input channel takes one word per cycle unless stalled; each holds the
// left and right pixel coordinates. The output channel returns one word with
// both bearing vectors for every input word, in order. The configuration
// channel writes focal length (index 0), principal point u (index 1) and v
// (index 2); it is always ready, and a write to any other index is ignored.
//
// Registers form the offsets, then the squares, then their sum; the per-bit
// quotient search and the output register follow. Throughput is one word per
// cycle while the receiver does not stall; the search runs one bit per stage.
// Reset clears all valid bits and loads the default camera registers. When
// the receiver stalls, the whole pipeline holds and the input is not ready
// while a result is waiting; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module stereo_pixel_to_unit_bearing_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    spb_pair_if.sink              i_in,
    spb_bearing_if.source         o_out,
    spb_cfg_if.sink               i_cfg
);
    import spb_pkg::*;

    localparam int SEARCH_LAT = Q_W + 1;
    localparam int VLEN = 3 + SEARCH_LAT;

    logic [PIX_W-1:0] r_focal;
    logic [PIX_W-1:0] r_cu;
    logic [PIX_W-1:0] r_cv;

    logic w_en;
    logic [VLEN-1:0] r_v;
    logic r_out_valid;

    logic [PIX_W-1:0] w_u [POINTS];
    logic [PIX_W-1:0] w_vv [POINTS];

    logic signed [DIFF_W-1:0] r_du [POINTS];
    logic signed [DIFF_W-1:0] r_dv [POINTS];
    logic [PIX_W-1:0] r_f1;

    logic [SQ_W-1:0] r_sqx2 [POINTS];
    logic [SQ_W-1:0] r_sqy2 [POINTS];
    logic [SQ_W-1:0] r_sqz2;
    logic [POINTS-1:0] r_negx2, r_negy2;

    logic [SQ_W-1:0]  r_sqx3 [POINTS];
    logic [SQ_W-1:0]  r_sqy3 [POINTS];
    logic [SQ_W-1:0]  r_sqz3;
    logic [SUM_W-1:0] r_s3 [POINTS];
    logic [POINTS-1:0] r_negx3, r_negy3;

    logic [3*POINTS-1:0] r_side [SEARCH_LAT];
    logic [3*POINTS-1:0] w_side3;

    logic [Q_W-1:0] w_qx [POINTS];
    logic [Q_W-1:0] w_qy [POINTS];
    logic [Q_W-1:0] w_qz [POINTS];

    logic signed [XY_W-1:0] n_x [POINTS];
    logic signed [XY_W-1:0] n_y [POINTS];
    logic        [Z_W-1:0]  n_z [POINTS];
    logic signed [XY_W-1:0] r_x [POINTS];
    logic signed [XY_W-1:0] r_y [POINTS];
    logic        [Z_W-1:0]  r_z [POINTS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal <= FOCAL_RESET;
            r_cu    <= CENTER_U_RESET;
            r_cv    <= CENTER_V_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_FOCAL:    r_focal <= i_cfg.data;
                CFG_CENTER_U: r_cu    <= i_cfg.data;
                CFG_CENTER_V: r_cv    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v         <= {r_v[VLEN-2:0], i_in.valid};
            r_out_valid <= r_v[VLEN-1];
        end
    end

    assign w_u[0]  = i_in.left_u;
    assign w_vv[0] = i_in.left_v;
    assign w_u[1]  = i_in.right_u;
    assign w_vv[1] = i_in.right_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1   <= r_focal;
            r_sqz2 <= SQ_W'(r_f1) * SQ_W'(r_f1);
            r_sqz3 <= r_sqz2;
        end
    end

    for (genvar p = 0; p < POINTS; p++) begin : g_pt
        logic [DIFF_W-1:0] w_ax;
        logic [DIFF_W-1:0] w_ay;
        logic [PIX_W-1:0]  w_mx;
        logic [PIX_W-1:0]  w_my;
        logic [SUM_W-1:0]  w_sum;

        assign w_ax = r_du[p][DIFF_W-1] ? DIFF_W'(-r_du[p]) : DIFF_W'(r_du[p]);
        assign w_ay = r_dv[p][DIFF_W-1] ? DIFF_W'(-r_dv[p]) : DIFF_W'(r_dv[p]);
        assign w_mx = w_ax[PIX_W-1:0];
        assign w_my = w_ay[PIX_W-1:0];
        assign w_sum = SUM_W'(r_sqx2[p]) + SUM_W'(r_sqy2[p]) + SUM_W'(r_sqz2);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_du[p]    <= signed'({1'b0, w_u[p]}) - signed'({1'b0, r_cu});
                r_dv[p]    <= signed'({1'b0, w_vv[p]}) - signed'({1'b0, r_cv});
                r_sqx2[p]  <= SQ_W'(w_mx) * SQ_W'(w_mx);
                r_sqy2[p]  <= SQ_W'(w_my) * SQ_W'(w_my);
                r_negx2[p] <= r_du[p][DIFF_W-1];
                r_negy2[p] <= r_dv[p][DIFF_W-1];
                r_sqx3[p]  <= r_sqx2[p];
                r_sqy3[p]  <= r_sqy2[p];
                r_s3[p]    <= w_sum;
                r_negx3[p] <= r_negx2[p];
                r_negy3[p] <= r_negy2[p];
            end
        end

        assign w_side3[3*p]   = r_negx3[p];
        assign w_side3[3*p+1] = r_negy3[p];
        assign w_side3[3*p+2] = (r_s3[p] == '0);

        spb_search u_x (.i_clk(i_clk), .i_en(w_en), .i_sq(r_sqx3[p]), .i_s(r_s3[p]),
                        .o_q(w_qx[p]));
        spb_search u_y (.i_clk(i_clk), .i_en(w_en), .i_sq(r_sqy3[p]), .i_s(r_s3[p]),
                        .o_q(w_qy[p]));
        spb_search u_z (.i_clk(i_clk), .i_en(w_en), .i_sq(r_sqz3), .i_s(r_s3[p]),
                        .o_q(w_qz[p]));

        always_comb begin
            logic sx, sy, sz;
            sx = r_side[SEARCH_LAT-1][3*p];
            sy = r_side[SEARCH_LAT-1][3*p+1];
            sz = r_side[SEARCH_LAT-1][3*p+2];
            if (sz) begin
                n_x[p] = '0;
                n_y[p] = '0;
                n_z[p] = Z_W'(Z_STRAIGHT);
            end else begin
                n_x[p] = sx ? -signed'(XY_W'(w_qx[p])) : signed'(XY_W'(w_qx[p]));
                n_y[p] = sy ? -signed'(XY_W'(w_qy[p])) : signed'(XY_W'(w_qy[p]));
                n_z[p] = w_qz[p];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_x[p] <= n_x[p];
                r_y[p] <= n_y[p];
                r_z[p] <= n_z[p];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_side3;
            for (int i = 1; i < SEARCH_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.left_x  = r_x[0];
    assign o_out.left_y  = r_y[0];
    assign o_out.left_z  = r_z[0];
    assign o_out.right_x = r_x[1];
    assign o_out.right_y = r_y[1];
    assign o_out.right_z = r_z[1];

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo bearing unit. Pixel pair words are sent
// with random gaps while the bearing side stalls at random. Each accepted
// word is turned into the expected pair of bearing vectors by an exact
// integer unprojection, and every result word is checked in order.
// ----------------------------------------------------------------------------
module tb;
    import spb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = 2'd3;
    localparam int SETTLE = 30;

    typedef struct packed {
        logic [15:0] lu;
        logic [15:0] lv;
        logic [15:0] ru;
        logic [15:0] rv;
    } t_pair;

    typedef struct packed {
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic        [14:0] lz;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic        [14:0] rz;
    } t_bearings;

    logic i_clk;
    logic i_rst_n;
    spb_pair_if    pair_ch();
    spb_bearing_if bear_ch();
    spb_cfg_if     cfg_ch();

    stereo_pixel_to_unit_bearing_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pair_ch.sink),
        .o_out   (bear_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    t_bearings   bearings_due[$];
    logic [15:0] cam_focal;
    logic [15:0] cam_cu;
    logic [15:0] cam_cv;
    int          errors;
    int          words_sent;
    int          words_checked;
    int          hold_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Round(mag * 2^14 / sqrt(s)) with ties away from zero, found bit-exactly
    // by searching for the largest q with (2q-1)^2 * s <= (2 * mag * 2^14)^2.
    function automatic int unit_ratio(longint unsigned mag, longint unsigned s);
        logic [127:0]    a2;
        logic [127:0]    lhs;
        longint unsigned a;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned k;
        a  = mag << (OUT_FRAC + 1);
        a2 = 128'(a) * 128'(a);
        lo = 0;
        hi = 64'd1 << OUT_FRAC;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            k   = 2 * mid - 1;
            lhs = 128'(k * k) * 128'(s);
            if (lhs <= a2) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return int'(lo);
    endfunction

    function automatic logic signed [15:0] clamp_xy(longint q);
        if (q > 32767) begin
            return 16'sd32767;
        end
        if (q < -32768) begin
            return -16'sd32768;
        end
        return 16'(q);
    endfunction

    function automatic void unproject(input logic [15:0] u, input logic [15:0] v,
                                      output logic signed [15:0] x,
                                      output logic signed [15:0] y,
                                      output logic [14:0] z);
        longint          du;
        longint          dv;
        longint          f;
        longint unsigned s;
        longint          q;
        du = longint'(u) - longint'(cam_cu);
        dv = longint'(v) - longint'(cam_cv);
        f  = longint'(cam_focal);
        s  = du * du + dv * dv + f * f;
        if (s == 0) begin
            x = '0;
            y = '0;
            q = 1 << OUT_FRAC;
        end else begin
            q = unit_ratio(du < 0 ? -du : du, s);
            x = clamp_xy(du < 0 ? -q : q);
            q = unit_ratio(dv < 0 ? -dv : dv, s);
            y = clamp_xy(dv < 0 ? -q : q);
            q = unit_ratio(f, s);
        end
        z = (q > 32767) ? 15'd32767 : 15'(q);
    endfunction

    function automatic t_bearings predict_bearings(t_pair p);
        t_bearings b;
        unproject(p.lu, p.lv, b.lx, b.ly, b.lz);
        unproject(p.ru, p.rv, b.rx, b.ry, b.rz);
        return b;
    endfunction

    task automatic report(string field, int got, int want);
        errors++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    endtask

    always @(posedge i_clk) begin
        t_bearings want;
        if (i_rst_n && bear_ch.valid && bear_ch.ready) begin
            if (bearings_due.size() == 0) begin
                errors++;
                $display("%0t: bearing word with nothing outstanding", $realtime);
            end else begin
                want = bearings_due.pop_front();
                words_checked++;
                if (bear_ch.left_x !== want.lx) report("left_x", bear_ch.left_x, want.lx);
                if (bear_ch.left_y !== want.ly) report("left_y", bear_ch.left_y, want.ly);
                if (bear_ch.left_z !== want.lz) report("left_z", bear_ch.left_z, want.lz);
                if (bear_ch.right_x !== want.rx) report("right_x", bear_ch.right_x, want.rx);
                if (bear_ch.right_y !== want.ry) report("right_y", bear_ch.right_y, want.ry);
                if (bear_ch.right_z !== want.rz) report("right_z", bear_ch.right_z, want.rz);
            end
        end
    end

    always @(negedge i_clk) begin
        int r;
        if (hold_cycles > 0) begin
            bear_ch.ready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                bear_ch.ready <= 1'b1;
            end else if (r < 97) begin
                bear_ch.ready <= 1'b0;
            end else begin
                bear_ch.ready <= 1'b0;
                hold_cycles   <= $urandom_range(5, 30);
            end
        end
    end

    task automatic send_pair(t_pair p, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : gap_len();
        if (gap > 0) begin
            pair_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pair_ch.left_u  = p.lu;
        pair_ch.left_v  = p.lv;
        pair_ch.right_u = p.ru;
        pair_ch.right_v = p.rv;
        pair_ch.valid   = 1'b1;
        @(posedge i_clk);
        while (!pair_ch.ready) @(posedge i_clk);
        bearings_due = {bearings_due, predict_bearings(p)};
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        pair_ch.valid = 1'b0;
        while (bearings_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_FOCAL:    cam_focal = value;
            CFG_CENTER_U: cam_cu    = value;
            CFG_CENTER_V: cam_cv    = value;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_camera(logic [15:0] f, logic [15:0] cu, logic [15:0] cv);
        write_reg(CFG_FOCAL, f);
        write_reg(CFG_CENTER_U, cu);
        write_reg(CFG_CENTER_V, cv);
    endtask

    function automatic logic [15:0] near(logic [15:0] c);
        int d;
        d = int'(c) + $signed($urandom_range(0, 4000)) - 2000;
        return (d < 0) ? 16'd0 : (d > 65535) ? 16'hFFFF : 16'(d);
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        if ($urandom_range(0, 1)) begin
            p = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
        end else begin
            p = {near(cam_cu), near(cam_cv), near(cam_cu), near(cam_cv)};
        end
        return p;
    endfunction

    task automatic test_defaults();
        send_pair({cam_cu, cam_cv, 16'd0, 16'd0});
        send_pair({16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF});
        send_pair({16'hFFFF, 16'd0, cam_cu, 16'hFFFF});
        send_pair({16'd5121, 16'd3839, 16'd13120, 16'd11840});
        send_pair({16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA});
        drain();
    endtask

    task automatic test_focal_extremes();
        set_camera(16'd16, 16'd0, 16'd0);
        send_pair({16'd0, 16'd0, 16'hFFFF, 16'hFFFF});
        send_pair({16'd1, 16'd0, 16'd0, 16'd16});
        drain();
        set_camera(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pair({16'd0, 16'd0, 16'hFFFF, 16'hFFFF});
        send_pair({16'hFFFE, 16'd0, 16'd0, 16'hFFFE});
        drain();
        // With zero focal length a point on the principal point looks straight
        // ahead; any other point gets a zero z component.
        set_camera(16'd0, 16'd1000, 16'd2000);
        send_pair({16'd1000, 16'd2000, 16'd1001, 16'd2000});
        send_pair({16'd1000, 16'd2001, 16'd0, 16'hFFFF});
        send_pair({16'd1000, 16'd2000, 16'd1000, 16'd2000});
        drain();
    endtask

    task automatic test_unused_index();
        write_reg(IDX_UNUSED, 16'h1234);
        send_pair({16'd1200, 16'd2100, 16'd900, 16'd1800});
        drain();
    endtask

    task automatic test_backpressure();
        set_camera(16'd8000, 16'd5120, 16'd3840);
        @(posedge i_clk);
        hold_cycles = 200;
        @(negedge i_clk);
        repeat (80) send_pair(random_pair(), 1);
        drain();
    endtask

    task automatic test_random_cameras();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_camera(16'd16, 16'd0, 16'hFFFF);
                1: set_camera(16'hFFFF, 16'd32768, 16'd0);
                default: set_camera(16'($urandom_range(16, 65535)), 16'($urandom),
                                    16'($urandom));
            endcase
            repeat (300) send_pair(random_pair());
            drain();
        end
    endtask

    initial begin
        errors        = 0;
        words_sent    = 0;
        words_checked = 0;
        hold_cycles   = 0;
        cam_focal     = FOCAL_RESET;
        cam_cu        = CENTER_U_RESET;
        cam_cv        = CENTER_V_RESET;
        i_rst_n       = 1'b0;
        pair_ch.valid   = 1'b0;
        pair_ch.left_u  = '0;
        pair_ch.left_v  = '0;
        pair_ch.right_u = '0;
        pair_ch.right_v = '0;
        bear_ch.ready   = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_defaults();
        test_focal_extremes();
        test_unused_index();
        test_backpressure();
        test_random_cameras();

        $display("Sent %0d pixel pair words and checked %0d bearing words across",
                 words_sent, words_checked);
        $display("default, extreme, zero-focal and random camera settings with stalls.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timed out waiting for bearing words.");
        $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> filelist.f
rtl/spb_pkg.sv
rtl/spb_if.sv
rtl/spb_search.sv
rtl/stereo_pixel_to_unit_bearing_unit.sv
sim/tb.sv
